// ===== rtl/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants of the FIFO thread scheduler
// Holds the slot count, derived widths, action, status and slot state codes,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int ACT_W     = 3;
    localparam int ID_W      = 8;
    localparam int STAT_W    = 2;
    localparam int STATE_W   = 2;

    // actions
    localparam logic [ACT_W-1:0] ACT_START    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READY    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PREEMPT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WAIT     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SCHEDULE = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] RES_OK    = 2'd0;
    localparam logic [STAT_W-1:0] RES_BAD   = 2'd1;
    localparam logic [STAT_W-1:0] RES_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] RES_FULL  = 2'd3;

    // slot states
    localparam logic [STATE_W-1:0] ST_UNUSED  = 2'd0;
    localparam logic [STATE_W-1:0] ST_READY   = 2'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING = 2'd2;
    localparam logic [STATE_W-1:0] ST_WAITING = 2'd3;

    typedef struct packed {
        logic load;    // capture the input word and read the tables
        logic commit;  // apply the update and load the output register
    } t_cmd;

    typedef struct packed {
        logic out_busy; // output register full and stalled this cycle
    } t_sts;

endpackage

// ===== rtl/fts_ctrl.sv =====
// ----------------------------------------------------------------------------
// fts_ctrl: controller of the FIFO thread scheduler
// Two-state sequencer: take a word, then commit it once the output is free.
// ----------------------------------------------------------------------------
module fts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fts_pkg::t_sts i_sts,
    output fts_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/fts_dp.sv =====
// ----------------------------------------------------------------------------
// fts_dp: datapath of the FIFO thread scheduler
// Slot state table, ready ring with head, tail and count, and output register.
// ----------------------------------------------------------------------------
module fts_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fts_pkg::t_cmd                i_cmd,
    output fts_pkg::t_sts                o_sts,
    input  logic [fts_pkg::ACT_W-1:0]    i_action,
    input  logic [fts_pkg::ID_W-1:0]     i_thread_id,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [fts_pkg::STAT_W-1:0]   o_status,
    output logic [fts_pkg::ID_W-1:0]     o_next_thread
);

    localparam int SW = fts_pkg::SLOT_W;
    localparam int CW = fts_pkg::CNT_W;
    localparam int IW = fts_pkg::ID_W;
    localparam logic [IW:0]   ID_LIM   = (IW + 1)'(fts_pkg::MAX_SLOTS);
    localparam logic [CW-1:0] CNT_FULL = CW'(fts_pkg::MAX_SLOTS);
    localparam logic [SW-1:0] IDX_LAST = SW'(fts_pkg::MAX_SLOTS - 1);

    // tables
    logic [fts_pkg::STATE_W-1:0] r_slot_mem [fts_pkg::MAX_SLOTS];
    logic [IW-1:0]               r_ring_mem [fts_pkg::MAX_SLOTS];
    logic [fts_pkg::MAX_SLOTS-1:0] r_slot_vld;

    // captured word and registered reads
    logic [fts_pkg::ACT_W-1:0]   r_act;
    logic [IW-1:0]               r_id;
    logic [fts_pkg::STATE_W-1:0] r_slot_rd;
    logic                        r_slot_rd_vld;
    logic [IW-1:0]               r_ring_rd;

    // ring pointers
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic [CW-1:0] r_count;

    // output register
    logic                        r_out_valid;
    logic [fts_pkg::STAT_W-1:0]  r_out_status;
    logic [IW-1:0]               r_out_next;

    // decision
    logic                        id_ok;
    logic [fts_pkg::STATE_W-1:0] cur_state;
    logic [fts_pkg::STAT_W-1:0]  res_status;
    logic [IW-1:0]               res_next;
    logic                        slot_we;
    logic [SW-1:0]               slot_waddr;
    logic [fts_pkg::STATE_W-1:0] slot_wdata;
    logic                        push;
    logic                        pop;

    assign id_ok     = ({1'b0, r_id} < ID_LIM);
    assign cur_state = r_slot_rd_vld ? r_slot_rd : fts_pkg::ST_UNUSED;

    always_comb begin
        res_status = fts_pkg::RES_OK;
        res_next   = '0;
        slot_we    = 1'b0;
        slot_waddr = r_id[SW-1:0];
        slot_wdata = fts_pkg::ST_WAITING;
        push       = 1'b0;
        pop        = 1'b0;
        case (r_act)
            fts_pkg::ACT_START: begin
                if (!id_ok || cur_state != fts_pkg::ST_UNUSED) begin
                    res_status = fts_pkg::RES_BAD;
                end else begin
                    slot_we = 1'b1;
                end
            end
            fts_pkg::ACT_READY, fts_pkg::ACT_PREEMPT: begin
                if (!id_ok) begin
                    res_status = fts_pkg::RES_BAD;
                end else if (r_count == CNT_FULL) begin
                    res_status = fts_pkg::RES_FULL;
                end else begin
                    slot_we    = 1'b1;
                    slot_wdata = fts_pkg::ST_READY;
                    push       = 1'b1;
                end
            end
            fts_pkg::ACT_WAIT: begin
                if (!id_ok) begin
                    res_status = fts_pkg::RES_BAD;
                end else begin
                    slot_we = 1'b1;
                end
            end
            fts_pkg::ACT_SCHEDULE: begin
                if (r_count == '0) begin
                    res_status = fts_pkg::RES_EMPTY;
                end else begin
                    res_next   = r_ring_rd;
                    slot_we    = 1'b1;
                    slot_waddr = r_ring_rd[SW-1:0];
                    slot_wdata = fts_pkg::ST_RUNNING;
                    pop        = 1'b1;
                end
            end
            default: begin
                res_status = fts_pkg::RES_BAD;
            end
        endcase
    end

    // capture the word and read both tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act         <= i_action;
            r_id          <= i_thread_id;
            r_slot_rd     <= r_slot_mem[i_thread_id[SW-1:0]];
            r_slot_rd_vld <= r_slot_vld[i_thread_id[SW-1:0]];
            r_ring_rd     <= r_ring_mem[r_head];
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (i_cmd.commit && push) begin
            r_ring_mem[r_tail] <= r_id;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (slot_we) begin
                    r_slot_vld[slot_waddr] <= 1'b1;
                end
                if (push) begin
                    r_tail  <= (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
                    r_count <= r_count + 1'b1;
                end
                if (pop) begin
                    r_head  <= (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= res_status;
            r_out_next   <= res_next;
        end
    end

    assign o_sts.out_busy = r_out_valid && i_stall;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_next_thread  = r_out_next;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("ring count above capacity");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == (r_count == '0 || r_count == CNT_FULL))
        else $error("ring pointers disagree with count");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed word did not reach output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && i_stall))
        else $error("commit over a stalled result");

endmodule

// ===== rtl/fifo_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// fifo_thread_scheduler: FIFO ready-queue thread scheduler
// Per-slot thread state and a ring of ready thread ids, served oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one word: an action and a
//   thread id. Output channel (o_valid / i_stall) returns one word per input:
//   a status and, for a successful schedule, the chosen thread id.
//   A word is taken at a rising edge with valid high and stall low.
// Sequence:
//   The word is captured and both tables (slot states, ready ring) are read
//   in the accept cycle; a later commit applies the update and loads the
//   output register once it is free, which makes the result visible.
//   A new word is not taken until the previous one is committed, set by the
//   single registered read port of each table followed by the update step.
// Stall:
//   A waiting result sits in the output register while a new word is taken;
//   that word is held before its update until the old result leaves.
// Reset:
//   i_rst_n is synchronous, active low. All slots read as unused (per-slot
//   valid bits are cleared), the ring is empty and the output is idle.
//   No clearing pass is needed; the block takes words right after reset.
// ----------------------------------------------------------------------------
module fifo_thread_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [fts_pkg::ACT_W-1:0]    i_action,
    input  logic [fts_pkg::ID_W-1:0]     i_thread_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [fts_pkg::STAT_W-1:0]   o_status,
    output logic [fts_pkg::ID_W-1:0]     o_next_thread
);

    fts_pkg::t_cmd cmd;
    fts_pkg::t_sts sts;

    // sequencer: accept, then commit when the output register is free
    fts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // tables, ring pointers and output register
    fts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_thread_id   (i_thread_id),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_next_thread (o_next_thread)
    );

endmodule
